/* hdl/ilpr_pkg.sv */
package ilpr_pkg;

  typedef enum logic [1:0] {
    ST_FWD    = 2'd0,
    ST_DROP   = 2'd1,
    ST_STORED = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_ROUTE = 1'b1;

  localparam logic [5:0]  MAX_LEN     = 6'd32;
  localparam logic [7:0]  TTL_MIN_FWD = 8'd2;

  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] ones;
    ones = 32'hFFFF_FFFF;
    len_mask = ~(ones >> len);
  endfunction

endpackage

/* hdl/ipv4_longest_prefix_router.sv */
// IPv4 longest prefix match routing table.
// The input channel carries one operation per transaction: add a route
// (operation 0) or route one datagram (operation 1). The result channel
// returns exactly one transaction per input: forwarded, dropped for TTL,
// route stored or table full.
// Each input is handled by a small sequencer that reads the entry memory one
// entry per cycle and runs it through one shared masked compare unit.
// After acceptance the sequencer scans the N stored routes (at most
// TABLE_ENTRIES), drains the compare register and then loads the result; a
// default route write or an empty table skips the scan. The next item is
// accepted in the cycle after the result is loaded, so the rate is set by the memory scan.
// in_ready is high only while the sequencer is idle; it stays high while a
// finished result waits on out_ready, but the following result is held back
// until the output register is free.
// Reset empties the table (the fill count goes to zero), sets the default
// route to direct on interface zero and clears out_valid.
module ipv4_longest_prefix_router #(
  parameter int TABLE_ENTRIES = 64,
  parameter int IFACE_BITS    = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_operation,
  input  logic [31:0]         in_route_prefix,
  input  logic [5:0]          in_prefix_len,
  input  logic                in_hop_present,
  input  logic [31:0]         in_hop_addr,
  input  logic [3:0]          in_iface_in,
  input  logic [31:0]         in_dest_addr,
  input  logic [7:0]          in_ttl_in,
  output logic                out_valid,
  input  logic                out_ready,
  output ilpr_pkg::status_t   out_status,
  output logic [3:0]          out_iface,
  output logic [31:0]         out_send_to,
  output logic [7:0]          out_ttl_out
);
  import ilpr_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam int IF_W  = IFACE_BITS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN
  } state_t;

  logic [31:0]     mem_pfx [TABLE_ENTRIES];
  logic [5:0]      mem_len [TABLE_ENTRIES];
  logic [32:0]     mem_hop [TABLE_ENTRIES];
  logic [IF_W-1:0] mem_if  [TABLE_ENTRIES];

  state_t          state_r;
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] scan_idx_r;
  logic [IDX_W-1:0] cmp_idx_r;
  logic            cmp_vld_r;

  logic            op_r;
  logic [5:0]      len_r;
  logic [31:0]     pfx_r;
  logic [32:0]     hopw_r;
  logic [IF_W-1:0] if_r;
  logic [31:0]     dst_r;
  logic [7:0]      ttl_r;

  logic [32:0]     dflt_hop_r;
  logic [IF_W-1:0] dflt_if_r;

  logic [5:0]      best_len_r;
  logic [32:0]     best_hop_r;
  logic [IF_W-1:0] best_if_r;
  logic            found_r;
  logic [IDX_W-1:0] slot_r;

  logic [31:0]     rd_pfx_r;
  logic [5:0]      rd_len_r;
  logic [32:0]     rd_hop_r;
  logic [IF_W-1:0] rd_if_r;

  logic            out_valid_r;
  status_t         out_status_r;
  logic [3:0]      out_iface_r;
  logic [31:0]     out_send_to_r;
  logic [7:0]      out_ttl_out_r;

  logic [5:0]      len_sat;
  logic [IF_W+3:0] if_ext;
  logic [IF_W-1:0] if_in;
  logic [IF_W+3:0] best_if_ext;
  logic [31:0]     key;
  logic            pfx_eq;
  logic            hit_route;
  logic            hit_add;
  logic            scan_last;
  logic            fin_go;
  logic            tbl_full;
  logic            wr_en;
  logic [IDX_W-1:0] wr_idx;

  always_comb begin
    len_sat     = (in_prefix_len > MAX_LEN) ? MAX_LEN : in_prefix_len;
    if_ext      = {{IF_W{1'b0}}, in_iface_in};
    if_in       = if_ext[IF_W-1:0];
    best_if_ext = {4'b0000, best_if_r};
    key         = (op_r == OP_ROUTE) ? (dst_r & len_mask(rd_len_r)) : pfx_r;
    pfx_eq      = (key == rd_pfx_r);
    hit_route   = pfx_eq && (rd_len_r > best_len_r);
    hit_add     = pfx_eq && (rd_len_r == len_r) && !found_r;
    scan_last   = ((CNT_W'(scan_idx_r) + CNT_W'(1)) == cnt_r);
    fin_go      = (state_r == S_FIN) && (!out_valid_r || out_ready);
    tbl_full    = (cnt_r == CNT_W'(TABLE_ENTRIES));
    wr_en       = fin_go && (op_r == OP_ADD) && (len_r != 6'd0) && (found_r || !tbl_full);
    wr_idx      = found_r ? slot_r : cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_pfx[wr_idx] <= pfx_r;
      mem_len[wr_idx] <= len_r;
      mem_hop[wr_idx] <= hopw_r;
      mem_if[wr_idx]  <= if_r;
    end
    if (state_r == S_SCAN) begin
      rd_pfx_r <= mem_pfx[scan_idx_r];
      rd_len_r <= mem_len[scan_idx_r];
      rd_hop_r <= mem_hop[scan_idx_r];
      rd_if_r  <= mem_if[scan_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      cmp_vld_r   <= 1'b0;
      dflt_hop_r  <= '0;
      dflt_if_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && !fin_go) begin
        out_valid_r <= 1'b0;
      end
      if (cmp_vld_r) begin
        if (op_r == OP_ROUTE && hit_route) begin
          best_len_r <= rd_len_r;
          best_hop_r <= rd_hop_r;
          best_if_r  <= rd_if_r;
        end
        if (op_r == OP_ADD && hit_add) begin
          found_r <= 1'b1;
          slot_r  <= cmp_idx_r;
        end
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r       <= in_operation;
            len_r      <= len_sat;
            pfx_r      <= in_route_prefix & len_mask(len_sat);
            hopw_r     <= {in_hop_present, in_hop_present ? in_hop_addr : 32'd0};
            if_r       <= if_in;
            dst_r      <= in_dest_addr;
            ttl_r      <= in_ttl_in;
            best_len_r <= '0;
            best_hop_r <= dflt_hop_r;
            best_if_r  <= dflt_if_r;
            found_r    <= 1'b0;
            slot_r     <= '0;
            scan_idx_r <= '0;
            if ((in_operation == OP_ADD && len_sat == 6'd0) || cnt_r == '0) begin
              state_r <= S_FIN;
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          cmp_vld_r <= 1'b1;
          cmp_idx_r <= scan_idx_r;
          if (scan_last) begin
            state_r <= S_DRAIN;
          end else begin
            scan_idx_r <= scan_idx_r + IDX_W'(1);
          end
        end
        S_DRAIN: begin
          cmp_vld_r <= 1'b0;
          state_r   <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            out_valid_r   <= 1'b1;
            state_r       <= S_IDLE;
            out_iface_r   <= 4'd0;
            out_send_to_r <= 32'd0;
            out_ttl_out_r <= 8'd0;
            if (op_r == OP_ADD) begin
              if (len_r == 6'd0) begin
                dflt_hop_r   <= hopw_r;
                dflt_if_r    <= if_r;
                out_status_r <= ST_STORED;
              end else if (found_r) begin
                out_status_r <= ST_STORED;
              end else if (!tbl_full) begin
                cnt_r        <= cnt_r + CNT_W'(1);
                out_status_r <= ST_STORED;
              end else begin
                out_status_r <= ST_FULL;
              end
            end else if (ttl_r < TTL_MIN_FWD) begin
              out_status_r <= ST_DROP;
            end else begin
              out_status_r  <= ST_FWD;
              out_iface_r   <= best_if_ext[3:0];
              out_send_to_r <= best_hop_r[32] ? best_hop_r[31:0] : dst_r;
              out_ttl_out_r <= ttl_r - 8'd1;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready    = (state_r == S_IDLE);
  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_iface   = out_iface_r;
  assign out_send_to = out_send_to_r;
  assign out_ttl_out = out_ttl_out_r;

endmodule

/* hdl/ilpr_checker.sv */
module ilpr_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input ilpr_pkg::status_t out_status,
  input logic [3:0]        out_iface,
  input logic [31:0]       out_send_to,
  input logic [7:0]        out_ttl_out
);
  import ilpr_pkg::*;

  // The block is not ready in the cycle after it takes a transaction.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an accepted transaction");

  a_no_result_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_send_to))
    else $error("stalled result changed or vanished");

  a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_FWD |->
      out_iface == 4'd0 && out_send_to == 32'd0 && out_ttl_out == 8'd0)
    else $error("non-forward result carries nonzero fields");

  a_fwd_ttl_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_FWD |-> out_ttl_out != 8'd0)
    else $error("forwarded datagram with zero TTL");

endmodule

bind ipv4_longest_prefix_router ilpr_checker u_ilpr_checker (.*);

/* sim/tb_ipv4_longest_prefix_router.sv */
`timescale 1ns / 100ps

module tb_ipv4_longest_prefix_router;
  import ilpr_pkg::*;

  localparam int ROUTE_SLOTS = 64;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int ITEMS_PER_PHASE = 370;
  localparam int DRAIN_CYCLES = 80;

  typedef struct {
    logic        op;
    logic [31:0] prefix;
    logic [5:0]  len;
    logic        hop_present;
    logic [31:0] hop;
    logic [3:0]  iface;
    logic [31:0] dest;
    logic [7:0]  ttl;
  } route_req_t;

  typedef struct {
    status_t     status;
    logic [3:0]  iface;
    logic [31:0] send_to;
    logic [7:0]  ttl;
  } route_resp_t;

  function automatic bit [31:0] prefix_mask(bit [5:0] n);
    bit [31:0] ones;
    ones = 32'hFFFF_FFFF;
    return (n == 6'd0) ? 32'd0 : ~(ones >> n);
  endfunction

  class lpm_scoreboard;
    bit [31:0]   slot_prefix[ROUTE_SLOTS];
    bit [5:0]    slot_len[ROUTE_SLOTS];
    bit          slot_has_hop[ROUTE_SLOTS];
    bit [31:0]   slot_hop[ROUTE_SLOTS];
    bit [3:0]    slot_iface[ROUTE_SLOTS];
    bit          slot_used[ROUTE_SLOTS];
    bit          dflt_has_hop;
    bit [31:0]   dflt_hop;
    bit [3:0]    dflt_iface;
    route_resp_t expected_q[$];
    int          mismatches;

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      dflt_has_hop = 1'b0;
      dflt_hop = '0;
      dflt_iface = '0;
      mismatches = 0;
    endfunction

    function route_resp_t resolve_route(route_req_t r);
      route_resp_t res;
      bit [5:0]    len;
      bit [31:0]   pfx;
      bit [31:0]   hop;
      bit          has_hop;
      bit [3:0]    ifc;
      bit [5:0]    best;
      int          slot;
      res.status = ST_FWD;
      res.iface = '0;
      res.send_to = '0;
      res.ttl = '0;
      if (r.op == OP_ADD) begin
        len = (r.len > MAX_LEN) ? MAX_LEN : r.len;
        hop = r.hop_present ? r.hop : 32'd0;
        if (len == 6'd0) begin
          dflt_has_hop = r.hop_present;
          dflt_hop = hop;
          dflt_iface = r.iface;
          res.status = ST_STORED;
          return res;
        end
        pfx = r.prefix & prefix_mask(len);
        slot = -1;
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (slot < 0 && slot_used[i] && slot_len[i] == len && slot_prefix[i] == pfx) slot = i;
        end
        for (int i = 0; i < ROUTE_SLOTS; i++) begin
          if (slot < 0 && !slot_used[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_FULL;
          return res;
        end
        slot_prefix[slot] = pfx;
        slot_len[slot] = len;
        slot_has_hop[slot] = r.hop_present;
        slot_hop[slot] = hop;
        slot_iface[slot] = r.iface;
        slot_used[slot] = 1'b1;
        res.status = ST_STORED;
        return res;
      end
      best = 6'd0;
      has_hop = dflt_has_hop;
      hop = dflt_hop;
      ifc = dflt_iface;
      for (int i = 0; i < ROUTE_SLOTS; i++) begin
        if (slot_used[i] && slot_len[i] > best &&
            (r.dest & prefix_mask(slot_len[i])) == slot_prefix[i]) begin
          best = slot_len[i];
          has_hop = slot_has_hop[i];
          hop = slot_hop[i];
          ifc = slot_iface[i];
        end
      end
      if (r.ttl < TTL_MIN_FWD) begin
        res.status = ST_DROP;
        return res;
      end
      res.iface = ifc;
      res.send_to = has_hop ? hop : r.dest;
      res.ttl = r.ttl - 8'd1;
      return res;
    endfunction

    function void note_request(route_req_t r);
      expected_q.insert(expected_q.size(), resolve_route(r));
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_outcome(route_resp_t got);
      route_resp_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result transaction with status %0d when none expected",
                                  got.status));
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.iface !== want.iface)
        report_mismatch($sformatf("iface %0h, expected %0h", got.iface, want.iface));
      if (got.send_to !== want.send_to)
        report_mismatch($sformatf("send_to %08h, expected %08h", got.send_to, want.send_to));
      if (got.ttl !== want.ttl)
        report_mismatch($sformatf("ttl_out %0d, expected %0d", got.ttl, want.ttl));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic        in_operation;
  logic [31:0] in_route_prefix;
  logic [5:0]  in_prefix_len;
  logic        in_hop_present;
  logic [31:0] in_hop_addr;
  logic [3:0]  in_iface_in;
  logic [31:0] in_dest_addr;
  logic [7:0]  in_ttl_in;
  logic        out_valid;
  logic        out_ready;
  status_t     out_status;
  logic [3:0]  out_iface;
  logic [31:0] out_send_to;
  logic [7:0]  out_ttl_out;

  lpm_scoreboard sb;
  int            send_idle_pct;
  int            recv_stall_pct;
  int            cycle_count;
  bit [31:0]     known_pfx[$];
  bit [5:0]      known_len[$];

  ipv4_longest_prefix_router DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_operation    (in_operation),
    .in_route_prefix (in_route_prefix),
    .in_prefix_len   (in_prefix_len),
    .in_hop_present  (in_hop_present),
    .in_hop_addr     (in_hop_addr),
    .in_iface_in     (in_iface_in),
    .in_dest_addr    (in_dest_addr),
    .in_ttl_in       (in_ttl_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_iface       (out_iface),
    .out_send_to     (out_send_to),
    .out_ttl_out     (out_ttl_out)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    route_resp_t got;
    if (rst_n && out_valid && out_ready) begin
      got.status = out_status;
      got.iface = out_iface;
      got.send_to = out_send_to;
      got.ttl = out_ttl_out;
      sb.check_outcome(got);
    end
  end

  function automatic route_req_t blank_req(logic op);
    route_req_t r;
    r.op = op;
    r.prefix = $urandom;
    r.len = 6'($urandom_range(63));
    r.hop_present = 1'($urandom_range(1));
    r.hop = $urandom;
    r.iface = 4'($urandom_range(15));
    r.dest = $urandom;
    r.ttl = 8'($urandom_range(255));
    return r;
  endfunction

  function automatic route_req_t add_req(logic [31:0] pfx, logic [5:0] len, logic has_hop,
                                         logic [31:0] hop, logic [3:0] ifc);
    route_req_t r;
    r = blank_req(OP_ADD);
    r.prefix = pfx;
    r.len = len;
    r.hop_present = has_hop;
    r.hop = hop;
    r.iface = ifc;
    return r;
  endfunction

  function automatic route_req_t route_req(logic [31:0] dest, logic [7:0] ttl);
    route_req_t r;
    r = blank_req(OP_ROUTE);
    r.dest = dest;
    r.ttl = ttl;
    return r;
  endfunction

  function automatic route_req_t random_req();
    route_req_t r;
    int         k;
    if ($urandom_range(99) < 40) begin
      r = blank_req(OP_ADD);
      if (known_pfx.size() != 0 && $urandom_range(99) < 40) begin
        k = $urandom_range(known_pfx.size() - 1);
        r.len = known_len[k];
        r.prefix = known_pfx[k] | ($urandom & ~prefix_mask(known_len[k]));
      end else if ($urandom_range(99) < 10) begin
        r.len = 6'($urandom_range(63, 33));
      end else if ($urandom_range(99) < 6) begin
        r.len = 6'd0;
      end else begin
        r.len = 6'($urandom_range(32, 1));
      end
    end else begin
      r = blank_req(OP_ROUTE);
      if (known_pfx.size() != 0 && $urandom_range(99) < 70) begin
        k = $urandom_range(known_pfx.size() - 1);
        r.dest = known_pfx[k] | ($urandom & ~prefix_mask(known_len[k]));
      end
      if ($urandom_range(99) < 15) r.ttl = 8'($urandom_range(1));
    end
    return r;
  endfunction

  task automatic send_req(route_req_t r);
    bit [5:0] len;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= r.op;
    in_route_prefix <= r.prefix;
    in_prefix_len <= r.len;
    in_hop_present <= r.hop_present;
    in_hop_addr <= r.hop;
    in_iface_in <= r.iface;
    in_dest_addr <= r.dest;
    in_ttl_in <= r.ttl;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (r.op == OP_ADD && r.len != 6'd0) begin
      len = (r.len > MAX_LEN) ? MAX_LEN : r.len;
      known_pfx.insert(known_pfx.size(), r.prefix & prefix_mask(len));
      known_len.insert(known_len.size(), len);
    end
    @(negedge clk);
  endtask

  task automatic run_phase(int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (ITEMS_PER_PHASE) send_req(random_req());
  endtask

  initial begin
    sb = new();
    cycle_count = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_ready = 1'b0;
    in_operation = OP_ADD;
    in_route_prefix = '0;
    in_prefix_len = '0;
    in_hop_present = 1'b0;
    in_hop_addr = '0;
    in_iface_in = '0;
    in_dest_addr = '0;
    in_ttl_in = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // First routes use the reset default; directed cases follow.
    send_req(route_req(32'hC0A8_0001, 8'd64));
    send_req(route_req(32'h0000_0000, 8'd0));
    send_req(route_req(32'hFFFF_FFFF, 8'd1));
    send_req(route_req(32'h1234_5678, 8'd2));
    send_req(route_req(32'h8765_4321, 8'd255));
    send_req(add_req(32'hDEAD_BEEF, 6'd0, 1'b1, 32'hFFFF_FFFF, 4'hF));
    send_req(route_req(32'h0101_0101, 8'd10));
    send_req(add_req(32'hFFFF_FFFF, 6'd32, 1'b0, 32'hFFFF_FFFF, 4'h5));
    send_req(route_req(32'hFFFF_FFFF, 8'd100));
    send_req(add_req(32'h0AFF_FFFF, 6'd8, 1'b1, 32'h0A00_0001, 4'h3));
    send_req(add_req(32'h0A0B_FFFF, 6'd16, 1'b1, 32'h0A0B_0001, 4'h7));
    send_req(route_req(32'h0A0B_0C0D, 8'd20));
    send_req(route_req(32'h0A0C_0000, 8'd20));
    send_req(add_req(32'h0A0B_0000, 6'd16, 1'b1, 32'h1234_5678, 4'h9));
    send_req(route_req(32'h0A0B_0001, 8'd30));
    send_req(add_req(32'h0A0B_0C0D, 6'd63, 1'b1, 32'h0000_0000, 4'h1));
    send_req(add_req(32'h0A0B_0C0E, 6'd33, 1'b0, 32'h5555_AAAA, 4'h4));
    send_req(route_req(32'h0A0B_0C0D, 8'd40));
    send_req(route_req(32'h0A0B_0C0E, 8'd40));
    send_req(add_req(32'h8000_0000, 6'd1, 1'b1, 32'hAAAA_5555, 4'h2));
    send_req(route_req(32'h8000_0001, 8'd50));
    send_req(route_req(32'h7FFF_FFFF, 8'd50));
    send_req(add_req(32'h0000_0000, 6'd0, 1'b0, 32'hFFFF_FFFF, 4'h0));
    send_req(route_req(32'h1234_5678, 8'd2));

    run_phase(0, 0);
    run_phase(81, 0);
    run_phase(0, 81);
    run_phase(16, 16);
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
